// File: hw/rtl/dtrt_pkg.sv
package dtrt_pkg;

  // Default grid and table limits
  localparam int DefMaxTilesX = 16;
  localparam int DefMaxTilesY = 8;
  localparam int DefMaxRects  = 64;

  // Divider geometry: 17-bit dividend covers the ceiling sums
  localparam int DivN  = 17;
  localparam int DivCw = 5;

  // Operation codes
  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_TAKE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_W = 2'd0;
  localparam logic [1:0] REG_FRAME_H = 2'd1;
  localparam logic [1:0] REG_TILE_W  = 2'd2;
  localparam logic [1:0] REG_TILE_H  = 2'd3;

  // Division selects, in sequencing order
  localparam logic [2:0] DIV_TA  = 3'd0;
  localparam logic [2:0] DIV_TD  = 3'd1;
  localparam logic [2:0] DIV_TX0 = 3'd2;
  localparam logic [2:0] DIV_TY0 = 3'd3;
  localparam logic [2:0] DIV_TX1 = 3'd4;
  localparam logic [2:0] DIV_TY1 = 3'd5;

  typedef struct packed {
    logic       in_load;
    logic       div_start;
    logic [2:0] div_sel;
    logic       grid_off;
    logic       walk_step;
    logic       wipe;
    logic       scan_init;
    logic       tx_inc;
    logic       run_begin;
    logic       row_end;
    logic       pi_inc;
    logic       apply;
    logic       emit_rd;
    logic       emit_next;
    logic       load_single;
    logic       load_rect;
    logic       acc;
  } dtrt_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       stale;
    logic       cfg_zero;
    logic       grid_on;
    logic       mark_rej;
    logic       total_zero;
    logic       walk_last;
    logic       row_end;
    logic       tile_dirty;
    logic       last_row;
    logic       seek_more;
    logic       nrects_zero;
    logic       emit_last;
    logic       out_free;
    logic [1:0] op;
  } dtrt_sts_t;

endpackage

// File: hw/rtl/dtrt_div.sv
module dtrt_div
  import dtrt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivN-1:0] dividend_i,
  input  logic [15:0]     divisor_i,
  output logic            done_o,
  output logic [DivN-1:0] quot_o
);

  logic            busy_q;
  logic [DivCw-1:0] cnt_q;
  logic [DivN-1:0] rem_q;
  logic [DivN-1:0] quo_q;
  logic [15:0]     dsr_q;
  logic            done_q;
  logic [DivN-1:0] trial;
  logic            fits;

  // One quotient bit per cycle, restoring form
  assign trial = {rem_q[DivN-2:0], quo_q[DivN-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCw'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCw'(DivN);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCw'(1);
        if (cnt_q == DivCw'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
      quo_q <= {quo_q[DivN-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: hw/rtl/dtrt_dp.sv
module dtrt_dp
  import dtrt_pkg::*;
#(
  parameter int MAX_TILES_X = DefMaxTilesX,
  parameter int MAX_TILES_Y = DefMaxTilesY,
  parameter int MAX_RECTS   = DefMaxRects
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] rect_x_i,
  input  logic [15:0] rect_y_i,
  input  logic [15:0] rect_w_i,
  input  logic [15:0] rect_h_i,
  input  logic        out_ready_i,
  input  dtrt_cmd_t   cmd_i,
  output dtrt_sts_t   sts_o,
  output logic        out_valid_o,
  output logic        accepted_o,
  output logic [7:0]  dirty_count_o,
  output logic        rect_valid_o,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [15:0] out_w_o,
  output logic [15:0] out_h_o,
  output logic        last_o
);

  localparam int XW   = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
  localparam int XCW  = $clog2(MAX_TILES_X + 1);
  localparam int YW   = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
  localparam int YCW  = $clog2(MAX_TILES_Y + 1);
  localparam int TOTW = $clog2(MAX_TILES_X * MAX_TILES_Y + 1);
  localparam int Runs = (MAX_TILES_X + 1) / 2;
  localparam int RNW  = (Runs > 1) ? $clog2(Runs) : 1;
  localparam int RNCW = $clog2(Runs + 1);
  localparam int RIW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int RCW  = $clog2(MAX_RECTS + 1);
  localparam int PXW  = 16 + XCW;
  localparam int PYW  = 16 + YCW;

  // Configuration and grid size
  logic [15:0] fw_q, fh_q, tw_q, th_q;
  logic        stale_q;
  logic [XCW-1:0] ta_q, ta_tmp_q;
  logic [YCW-1:0] td_q;
  logic           ta_ok_q;

  // Latched transaction
  logic [1:0]  op_q;
  logic [15:0] x_q, y_q, w_q, h_q;

  // Dirty bitmap and count
  logic [MAX_TILES_Y-1:0][MAX_TILES_X-1:0] map_q;
  logic [TOTW-1:0] total_q;

  // Mark bounds and walk cursor
  logic [XW-1:0] tx0_q, tx1_q, wx_q;
  logic [YW-1:0] ty1_q, wy_q;

  // Scan state
  logic [XCW-1:0] tx_q;
  logic [YW-1:0]  ty_q;
  logic [PXW-1:0] px_q;
  logic [PYW-1:0] py_q;
  logic [XW-1:0]  start_q;
  logic [15:0]    spx_q;
  logic           bank_q;
  logic [RNCW-1:0] pi_q;
  logic [RNCW-1:0] pcnt_q, cur_q;
  logic [RCW-1:0] nrects_q;
  logic [RIW-1:0] emit_q;

  // Run lists, two banks: current row and row above
  logic [XW-1:0]  run_start_q [2][Runs];
  logic [XCW-1:0] run_end_q   [2][Runs];
  logic [RIW-1:0] run_rect_q  [2][Runs];

  // Rectangle table
  logic [47:0] xyw_mem [MAX_RECTS];
  logic [15:0] bot_mem [MAX_RECTS];
  logic [47:0] xyw_rd_q;
  logic [15:0] bot_rd_q;

  // Output register
  logic        ov_q;
  logic        acc_q, rv_q, last_q;
  logic [7:0]  dc_q;
  logic [15:0] ox_q, oy_q, ow_q, oh_q;

  // Divider
  logic [DivN-1:0] dividend, quot;
  logic [15:0]     divisor;
  logic            div_done;
  logic [15:0]     vw, vh;

  dtrt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Pick division operands
  always_comb begin
    vw = (w_q < (fw_q - x_q)) ? w_q : (fw_q - x_q);
    vh = (h_q < (fh_q - y_q)) ? h_q : (fh_q - y_q);
    dividend = '0;
    divisor  = tw_q;
    case (cmd_i.div_sel)
      DIV_TA:  dividend = {1'b0, fw_q} + {1'b0, tw_q} - DivN'(1);
      DIV_TD: begin
        dividend = {1'b0, fh_q} + {1'b0, th_q} - DivN'(1);
        divisor  = th_q;
      end
      DIV_TX0: dividend = {1'b0, x_q};
      DIV_TY0: begin
        dividend = {1'b0, y_q};
        divisor  = th_q;
      end
      DIV_TX1: dividend = {1'b0, x_q} + {1'b0, vw} - DivN'(1);
      DIV_TY1: begin
        dividend = {1'b0, y_q} + {1'b0, vh} - DivN'(1);
        divisor  = th_q;
      end
      default: dividend = '0;
    endcase
  end

  // Scan helpers
  logic           tile_dirty, grid_on;
  logic           prior_ok, matched;
  logic [XW-1:0]  p_start;
  logic [XCW-1:0] p_end;
  logic [RIW-1:0] p_rect, ri;
  logic [15:0]    right, bottom, rw;
  logic [PYW-1:0] bot_full;
  logic           create;

  assign grid_on    = ta_q != '0;
  assign tile_dirty = (tx_q < ta_q) && map_q[ty_q][tx_q[XW-1:0]];
  assign p_start    = run_start_q[~bank_q][pi_q[RNW-1:0]];
  assign p_end      = run_end_q[~bank_q][pi_q[RNW-1:0]];
  assign p_rect     = run_rect_q[~bank_q][pi_q[RNW-1:0]];
  assign prior_ok   = pi_q < pcnt_q;
  assign matched    = prior_ok && (p_start == start_q) && (p_end == tx_q);
  assign create     = !matched && (nrects_q < RCW'(MAX_RECTS));
  assign ri         = matched ? p_rect : nrects_q[RIW-1:0];
  assign right      = (px_q > PXW'(fw_q)) ? fw_q : px_q[15:0];
  assign rw         = right - spx_q;
  assign bot_full   = py_q + PYW'(th_q);
  assign bottom     = (bot_full > PYW'(fh_q)) ? fh_q : bot_full[15:0];

  // Status to the controller
  always_comb begin
    sts_o.div_done    = div_done;
    sts_o.stale       = stale_q;
    sts_o.cfg_zero    = (fw_q == '0) || (fh_q == '0) || (tw_q == '0) || (th_q == '0);
    sts_o.grid_on     = grid_on;
    sts_o.mark_rej    = !grid_on || (w_q == '0) || (h_q == '0) ||
                        (x_q >= fw_q) || (y_q >= fh_q);
    sts_o.total_zero  = total_q == '0;
    sts_o.walk_last   = (wx_q == tx1_q) && (wy_q == ty1_q);
    sts_o.row_end     = tx_q == ta_q;
    sts_o.tile_dirty  = tile_dirty;
    sts_o.last_row    = YCW'(ty_q) == (td_q - YCW'(1));
    sts_o.seek_more   = prior_ok && (p_start < start_q);
    sts_o.nrects_zero = nrects_q == '0;
    sts_o.emit_last   = (RCW'(emit_q) + RCW'(1)) == nrects_q;
    sts_o.out_free    = !ov_q || out_ready_i;
    sts_o.op          = op_q;
  end

  // Configuration registers and grid size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= '0;
      fh_q    <= '0;
      tw_q    <= '0;
      th_q    <= '0;
      stale_q <= 1'b0;
      ta_q    <= '0;
      td_q    <= '0;
      ta_ok_q <= 1'b0;
      ta_tmp_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_W: fw_q <= cfg_data_i;
        REG_FRAME_H: fh_q <= cfg_data_i;
        REG_TILE_W:  tw_q <= cfg_data_i;
        REG_TILE_H:  th_q <= cfg_data_i;
        default:     fw_q <= fw_q;
      endcase
      stale_q <= 1'b1;
      ta_q    <= '0;
      td_q    <= '0;
    end else if (cmd_i.grid_off) begin
      stale_q <= 1'b0;
      ta_q    <= '0;
      td_q    <= '0;
    end else if (div_done && (cmd_i.div_sel == DIV_TA)) begin
      ta_ok_q  <= quot <= DivN'(MAX_TILES_X);
      ta_tmp_q <= XCW'(quot);
    end else if (div_done && (cmd_i.div_sel == DIV_TD)) begin
      stale_q <= 1'b0;
      if (ta_ok_q && (quot <= DivN'(MAX_TILES_Y))) begin
        ta_q <= ta_tmp_q;
        td_q <= YCW'(quot);
      end else begin
        ta_q <= '0;
        td_q <= '0;
      end
    end
  end

  // Latch the transaction and mark bounds
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q <= op_i;
      x_q  <= rect_x_i;
      y_q  <= rect_y_i;
      w_q  <= rect_w_i;
      h_q  <= rect_h_i;
    end
    if (div_done) begin
      case (cmd_i.div_sel)
        DIV_TX0: tx0_q <= XW'(quot);
        DIV_TX1: tx1_q <= XW'(quot);
        DIV_TY1: ty1_q <= YW'(quot);
        default: tx0_q <= tx0_q;
      endcase
    end
  end

  // Bitmap, count and scan control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q    <= '0;
      total_q  <= '0;
      wx_q     <= '0;
      wy_q     <= '0;
      tx_q     <= '0;
      ty_q     <= '0;
      px_q     <= '0;
      py_q     <= '0;
      bank_q   <= 1'b0;
      pi_q     <= '0;
      pcnt_q   <= '0;
      cur_q    <= '0;
      nrects_q <= '0;
      emit_q   <= '0;
    end else if (cfg_we_i || cmd_i.wipe) begin
      map_q   <= '0;
      total_q <= '0;
      pcnt_q  <= '0;
    end else begin
      // seed the walk cursor as the lower bounds arrive
      if (div_done && (cmd_i.div_sel == DIV_TX0)) wx_q <= XW'(quot);
      if (div_done && (cmd_i.div_sel == DIV_TY0)) wy_q <= YW'(quot);

      if (cmd_i.walk_step) begin
        if (!map_q[wy_q][wx_q]) begin
          map_q[wy_q][wx_q] <= 1'b1;
          total_q <= total_q + TOTW'(1);
        end
        if (wx_q == tx1_q) begin
          wx_q <= tx0_q;
          wy_q <= wy_q + YW'(1);
        end else begin
          wx_q <= wx_q + XW'(1);
        end
      end

      if (cmd_i.scan_init) begin
        tx_q     <= '0;
        ty_q     <= '0;
        px_q     <= '0;
        py_q     <= '0;
        bank_q   <= 1'b0;
        pi_q     <= '0;
        pcnt_q   <= '0;
        cur_q    <= '0;
        nrects_q <= '0;
        emit_q   <= '0;
      end

      if (cmd_i.tx_inc || cmd_i.run_begin) begin
        tx_q <= tx_q + XCW'(1);
        px_q <= px_q + PXW'(tw_q);
      end

      // advance to the next row, old row becomes the row above
      if (cmd_i.row_end) begin
        tx_q   <= '0;
        px_q   <= '0;
        ty_q   <= ty_q + YW'(1);
        py_q   <= py_q + PYW'(th_q);
        bank_q <= ~bank_q;
        pcnt_q <= cur_q;
        cur_q  <= '0;
        pi_q   <= '0;
      end

      if (cmd_i.pi_inc) pi_q <= pi_q + RNCW'(1);

      // close a run: extend or open a rectangle, drop its tiles; a full table leaves an unmatched run as it is
      if (cmd_i.apply && (matched || create)) begin
        for (int i = 0; i < MAX_TILES_X; i++) begin
          if ((XCW'(i) >= XCW'(start_q)) && (XCW'(i) < tx_q)) map_q[ty_q][i] <= 1'b0;
        end
        total_q <= total_q - TOTW'(tx_q - XCW'(start_q));
        if (create) nrects_q <= nrects_q + RCW'(1);
        if (cur_q < RNCW'(Runs)) cur_q <= cur_q + RNCW'(1);
      end

      if (cmd_i.emit_next) emit_q <= emit_q + RIW'(1);
    end
  end

  // Run lists and rectangle table
  always_ff @(posedge clk_i) begin
    if (cmd_i.run_begin) begin
      start_q <= tx_q[XW-1:0];
      spx_q   <= px_q[15:0];
    end
    if (cmd_i.apply && (matched || create)) begin
      if (cur_q < RNCW'(Runs)) begin
        run_start_q[bank_q][cur_q[RNW-1:0]] <= start_q;
        run_end_q[bank_q][cur_q[RNW-1:0]]   <= tx_q;
        run_rect_q[bank_q][cur_q[RNW-1:0]]  <= ri;
      end
      bot_mem[ri] <= bottom;
      if (create) xyw_mem[ri] <= {spx_q, py_q[15:0], rw};
    end
    if (cmd_i.emit_rd) begin
      xyw_rd_q <= xyw_mem[emit_q];
      bot_rd_q <= bot_mem[emit_q];
    end
  end

  // Output register
  logic [7:0] dcnt;
  assign dcnt = (32'(total_q) > 32'd255) ? 8'hFF : 8'(total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.load_rect) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      acc_q  <= cmd_i.acc;
      dc_q   <= dcnt;
      rv_q   <= 1'b0;
      ox_q   <= '0;
      oy_q   <= '0;
      ow_q   <= '0;
      oh_q   <= '0;
      last_q <= 1'b1;
    end else if (cmd_i.load_rect) begin
      acc_q  <= 1'b1;
      dc_q   <= dcnt;
      rv_q   <= 1'b1;
      ox_q   <= xyw_rd_q[47:32];
      oy_q   <= xyw_rd_q[31:16];
      ow_q   <= xyw_rd_q[15:0];
      oh_q   <= bot_rd_q - xyw_rd_q[31:16];
      last_q <= sts_o.emit_last;
    end
  end

  assign out_valid_o   = ov_q;
  assign accepted_o    = acc_q;
  assign dirty_count_o = dc_q;
  assign rect_valid_o  = rv_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_w_o       = ow_q;
  assign out_h_o       = oh_q;
  assign last_o        = last_q;

endmodule

// File: hw/rtl/dtrt_ctrl.sv
module dtrt_ctrl
  import dtrt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dtrt_sts_t sts_i,
  output dtrt_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREP     = 4'd1;
  localparam logic [3:0] S_DIV_GO   = 4'd2;
  localparam logic [3:0] S_DIV_WAIT = 4'd3;
  localparam logic [3:0] S_DISPATCH = 4'd4;
  localparam logic [3:0] S_WALK     = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_RUN      = 4'd7;
  localparam logic [3:0] S_SEEK     = 4'd8;
  localparam logic [3:0] S_APPLY    = 4'd9;
  localparam logic [3:0] S_EMIT_CHK = 4'd10;
  localparam logic [3:0] S_EMIT_RD  = 4'd11;
  localparam logic [3:0] S_EMIT_LD  = 4'd12;
  localparam logic [3:0] S_RESP     = 4'd13;

  logic [3:0] state_q, state_d;
  logic [2:0] sel_q, sel_d;
  logic       acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DIV_TA;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      acc_q   <= acc_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  // Sequence one transaction
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    acc_d   = acc_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    cmd_o.acc     = acc_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (!sts_i.stale) begin
          state_d = S_DISPATCH;
        end else if (sts_i.cfg_zero) begin
          cmd_o.grid_off = 1'b1;
          state_d = S_DISPATCH;
        end else begin
          sel_d   = DIV_TA;
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          if (sel_q == DIV_TD) begin
            state_d = S_DISPATCH;
          end else if (sel_q == DIV_TY1) begin
            state_d = S_WALK;
          end else begin
            sel_d   = sel_q + 3'd1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_MARK: begin
            if (sts_i.mark_rej) begin
              acc_d   = 1'b0;
              state_d = S_RESP;
            end else begin
              sel_d   = DIV_TX0;
              state_d = S_DIV_GO;
            end
          end
          OP_TAKE: begin
            if (!sts_i.grid_on || sts_i.total_zero) begin
              acc_d   = sts_i.grid_on;
              state_d = S_RESP;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d = S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd_o.wipe = 1'b1;
            acc_d   = sts_i.grid_on;
            state_d = S_RESP;
          end
          default: begin
            acc_d   = 1'b0;
            state_d = S_RESP;
          end
        endcase
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          acc_d   = 1'b1;
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        if (sts_i.row_end) begin
          cmd_o.row_end = 1'b1;
          if (sts_i.last_row) state_d = S_EMIT_CHK;
        end else if (sts_i.tile_dirty) begin
          cmd_o.run_begin = 1'b1;
          state_d = S_RUN;
        end else begin
          cmd_o.tx_inc = 1'b1;
        end
      end
      S_RUN: begin
        if (sts_i.tile_dirty) cmd_o.tx_inc = 1'b1;
        else state_d = S_SEEK;
      end
      S_SEEK: begin
        if (sts_i.seek_more) cmd_o.pi_inc = 1'b1;
        else state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = S_SCAN;
      end
      S_EMIT_CHK: begin
        if (sts_i.nrects_zero) begin
          acc_d   = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.load_rect = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_single = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/dirty_tile_region_tracker.sv
// Channel  | Handshake                   | Payload
// in       | in_valid_i / in_ready_o     | op_i, rect_x_i, rect_y_i, rect_w_i, rect_h_i
// out      | out_valid_o / out_ready_i   | accepted_o .. last_o
// cfg      | cfg_we_i (no wait)          | cfg_idx_i, cfg_data_i
//
// One transaction at a time; the next is taken once the last result sits in the output register.
// The first transaction after a register write sizes the grid first, with two divisions.
// Mark: four divisions on the shared divider, then one covered tile marked per cycle.
// Take: scans tile by tile and row by row; each run seeks past the runs above that start earlier,
// then is applied; each rectangle is then emitted with a table read and a load.
// Reset and every register write clear the bitmap at once; a stalled output holds the sequencer.
module dirty_tile_region_tracker
  import dtrt_pkg::*;
#(
  parameter int MAX_TILES_X = DefMaxTilesX,
  parameter int MAX_TILES_Y = DefMaxTilesY,
  parameter int MAX_RECTS   = DefMaxRects
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] rect_x_i,
  input  logic [15:0] rect_y_i,
  input  logic [15:0] rect_w_i,
  input  logic [15:0] rect_h_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [7:0]  dirty_count_o,
  output logic        rect_valid_o,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [15:0] out_w_o,
  output logic [15:0] out_h_o,
  output logic        last_o
);

  dtrt_cmd_t cmd;
  dtrt_sts_t sts;

  dtrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtrt_dp #(
    .MAX_TILES_X (MAX_TILES_X),
    .MAX_TILES_Y (MAX_TILES_Y),
    .MAX_RECTS   (MAX_RECTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_w_i      (rect_w_i),
    .rect_h_i      (rect_h_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .accepted_o    (accepted_o),
    .dirty_count_o (dirty_count_o),
    .rect_valid_o  (rect_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_w_o       (out_w_o),
    .out_h_o       (out_h_o),
    .last_o        (last_o)
  );

endmodule

// File: hw/rtl/dtrt_chk.sv
module dtrt_chk
  import dtrt_pkg::*;
#(
  parameter int MAX_TILES_X = DefMaxTilesX,
  parameter int MAX_TILES_Y = DefMaxTilesY
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        accepted_o,
  input logic [7:0]  dirty_count_o,
  input logic        rect_valid_o,
  input logic [15:0] out_x_o,
  input logic [15:0] out_y_o,
  input logic [15:0] out_w_o,
  input logic [15:0] out_h_o,
  input logic        last_o
);

  // Hold a stalled transaction
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(last_o) && $stable(out_x_o))
    else $error("stalled result changed");

  // Empty result carries zero geometry
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rect_valid_o |-> (out_x_o == '0) && (out_y_o == '0) &&
      (out_w_o == '0) && (out_h_o == '0) && last_o)
    else $error("empty result with geometry");

  // Extracted rectangle is never empty and always accepted
  a_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rect_valid_o |-> accepted_o && (out_w_o != '0) && (out_h_o != '0))
    else $error("bad extracted rectangle");

  // Count stays within the grid
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(dirty_count_o) <= MAX_TILES_X * MAX_TILES_Y)
    else $error("dirty count exceeds grid");

endmodule

bind dirty_tile_region_tracker dtrt_chk #(
  .MAX_TILES_X (MAX_TILES_X),
  .MAX_TILES_Y (MAX_TILES_Y)
) u_chk (.*);

// File: sim/tb.sv
module tb;
  import dtrt_pkg::*;

  localparam int TilesX = 16;
  localparam int TilesY = 8;
  localparam int RectCap = 64;
  localparam int RunCap = (TilesX + 1) / 2;
  localparam int StallLimit = 20000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] x, y, w, h;
  } job_t;

  typedef struct packed {
    logic        acc;
    logic [7:0]  cnt;
    logic        rv;
    logic [15:0] x, y, w, h;
    logic        last;
  } tile_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_FRAME_W;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = OP_MARK;
  logic [15:0] rect_x_i = '0, rect_y_i = '0, rect_w_i = '0, rect_h_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o, rect_valid_o, last_o;
  logic [7:0]  dirty_count_o;
  logic [15:0] out_x_o, out_y_o, out_w_o, out_h_o;

  dirty_tile_region_tracker dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Pending jobs, expected results, pacing knobs
  job_t        pending_jobs[$];
  job_t        cur_job;
  tile_res_t   expected_res[$];
  int          send_idle_pct = 23;
  int          recv_idle_pct = 77;
  int          hold_request = 0;
  int          mismatches = 0;

  // Shadow of the tracker state
  int unsigned frame_w, frame_h, tile_w, tile_h;
  int unsigned grid_x, grid_y, dirty_tot;
  bit          dirty_bits[TilesX*TilesY];

  function automatic bit grid_enabled();
    return grid_x != 0 && grid_y != 0;
  endfunction

  task automatic wipe_tiles();
    foreach (dirty_bits[i]) dirty_bits[i] = 1'b0;
    dirty_tot = 0;
  endtask

  task automatic resize_grid();
    int unsigned ta, td;
    wipe_tiles();
    grid_x = 0;
    grid_y = 0;
    if (frame_w != 0 && frame_h != 0 && tile_w != 0 && tile_h != 0) begin
      ta = (frame_w + tile_w - 1) / tile_w;
      td = (frame_h + tile_h - 1) / tile_h;
      if (ta <= TilesX && td <= TilesY) begin
        grid_x = ta;
        grid_y = td;
      end
    end
  endtask

  task automatic push_res(bit acc, bit rv, int unsigned x, int unsigned y,
                          int unsigned w, int unsigned h, bit last);
    tile_res_t r;
    r.acc = acc;
    r.cnt = dirty_tot > 255 ? 8'd255 : dirty_tot[7:0];
    r.rv = rv;
    r.x = x[15:0];
    r.y = y[15:0];
    r.w = w[15:0];
    r.h = h[15:0];
    r.last = last;
    expected_res = {expected_res, r};
  endtask

  function automatic bit mark_tiles(job_t j);
    int unsigned vw, vh, tx0, ty0, tx1, ty1;
    if (!grid_enabled() || j.w == 0 || j.h == 0 || j.x >= frame_w || j.y >= frame_h)
      return 1'b0;
    vw = (j.w < frame_w - j.x) ? j.w : frame_w - j.x;
    vh = (j.h < frame_h - j.y) ? j.h : frame_h - j.y;
    tx0 = j.x / tile_w;
    ty0 = j.y / tile_h;
    tx1 = (j.x + vw - 1) / tile_w;
    ty1 = (j.y + vh - 1) / tile_h;
    for (int unsigned ty = ty0; ty <= ty1 && ty < grid_y; ty++)
      for (int unsigned tx = tx0; tx <= tx1 && tx < grid_x; tx++)
        if (!dirty_bits[ty*TilesX+tx]) begin
          dirty_bits[ty*TilesX+tx] = 1'b1;
          dirty_tot++;
        end
    return 1'b1;
  endfunction

  // Scan rows, merge runs that line up with the row above, emit rectangles
  task automatic scan_rects();
    int unsigned rx[RectCap], ry[RectCap], rw[RectCap], rh[RectCap];
    int unsigned ps[RunCap], pe[RunCap], pr[RunCap];
    int unsigned cs[RunCap], ce[RunCap], cr[RunCap];
    int unsigned prc, nrects, cur, pi, tx, st, en, ri, bottom, right;
    bit matched;
    if (!grid_enabled() || dirty_tot == 0) begin
      push_res(grid_enabled(), 0, 0, 0, 0, 0, 1);
      return;
    end
    prc = 0;
    nrects = 0;
    for (int unsigned ty = 0; ty < grid_y; ty++) begin
      cur = 0;
      pi = 0;
      tx = 0;
      while (tx < grid_x) begin
        if (!dirty_bits[ty*TilesX+tx]) begin
          tx++;
          continue;
        end
        st = tx;
        while (tx < grid_x && dirty_bits[ty*TilesX+tx]) tx++;
        en = tx;
        while (pi < prc && ps[pi] < st) pi++;
        matched = pi < prc && ps[pi] == st && pe[pi] == en;
        if (matched) begin
          bottom = (ty + 1) * tile_h;
          if (bottom > frame_h) bottom = frame_h;
          ri = pr[pi];
          rh[ri] = bottom - ry[ri];
        end else if (nrects < RectCap) begin
          right = en * tile_w;
          if (right > frame_w) right = frame_w;
          bottom = ty * tile_h + tile_h;
          if (bottom > frame_h) bottom = frame_h;
          ri = nrects++;
          rx[ri] = st * tile_w;
          ry[ri] = ty * tile_h;
          rw[ri] = right - rx[ri];
          rh[ri] = bottom - ry[ri];
        end else begin
          // table full: run stays dirty and out of matching
          continue;
        end
        for (int unsigned i = st; i < en; i++) dirty_bits[ty*TilesX+i] = 1'b0;
        dirty_tot -= en - st;
        if (cur < RunCap) begin
          cs[cur] = st;
          ce[cur] = en;
          cr[cur] = ri;
          cur++;
        end
      end
      ps = cs;
      pe = ce;
      pr = cr;
      prc = cur;
    end
    if (nrects == 0) begin
      push_res(1, 0, 0, 0, 0, 0, 1);
      return;
    end
    for (int unsigned k = 0; k < nrects; k++)
      push_res(1, 1, rx[k], ry[k], rw[k], rh[k], k + 1 == nrects);
  endtask

  task automatic predict_job(job_t j);
    bit on;
    case (j.op)
      OP_MARK: begin
        on = mark_tiles(j);
        push_res(on, 0, 0, 0, 0, 0, 1);
      end
      OP_TAKE: scan_rects();
      OP_CLEAR: begin
        on = grid_enabled();
        wipe_tiles();
        push_res(on, 0, 0, 0, 0, 0, 1);
      end
      default: push_res(0, 0, 0, 0, 0, 0, 1);
    endcase
  endtask

  // Driver: advance to the next job when the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_job(cur_job);
      if (!in_valid_i || in_ready_o) begin
        if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_job = pending_jobs.pop_front();
          op_i <= cur_job.op;
          rect_x_i <= cur_job.x;
          rect_y_i <= cur_job.y;
          rect_w_i <= cur_job.w;
          rect_h_i <= cur_job.h;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results, pace ready, watch for a hang
  int hold_cnt = 0;
  int quiet_cycles = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    tile_res_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {accepted_o, dirty_count_o, rect_valid_o, out_x_o, out_y_o, out_w_o,
               out_h_o, last_o};
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_res.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      quiet_cycles = ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) ? 0 :
                     quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb failed");
        $finish;
      end else begin
        if (hold_request > 0) begin
          hold_cnt = hold_request;
          hold_request = 0;
        end
        if (hold_cnt > 0) begin
          hold_cnt--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= $urandom_range(99) >= recv_idle_pct;
        end
      end
    end
  end

  task automatic set_grid(int unsigned fw, int unsigned fh, int unsigned tw,
                          int unsigned th);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_FRAME_W;
    cfg_data_i <= fw[15:0];
    @(posedge clk_i);
    cfg_idx_i <= REG_FRAME_H;
    cfg_data_i <= fh[15:0];
    @(posedge clk_i);
    cfg_idx_i <= REG_TILE_W;
    cfg_data_i <= tw[15:0];
    @(posedge clk_i);
    cfg_idx_i <= REG_TILE_H;
    cfg_data_i <= th[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frame_w = fw;
    frame_h = fh;
    tile_w = tw;
    tile_h = th;
    resize_grid();
  endtask

  task automatic add_job(logic [1:0] op, int unsigned x, int unsigned y,
                         int unsigned w, int unsigned h);
    job_t j;
    j.op = op;
    j.x = x[15:0];
    j.y = y[15:0];
    j.w = w[15:0];
    j.h = h[15:0];
    pending_jobs = {pending_jobs, j};
  endtask

  // Mostly marks inside the frame, a few wild ones
  task automatic add_random_jobs(int n);
    int unsigned r, x, y, w, h, span_w, span_h;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      span_w = frame_w > 0 ? frame_w : 64;
      span_h = frame_h > 0 ? frame_h : 64;
      x = $urandom_range(span_w + span_w / 8);
      y = $urandom_range(span_h + span_h / 8);
      w = $urandom_range(1, 3 * (tile_w > 0 ? tile_w : 8));
      h = $urandom_range(1, 3 * (tile_h > 0 ? tile_h : 8));
      if (x > 65535) x = 65535;
      if (y > 65535) y = 65535;
      if (w > 65535) w = 65535;
      if (h > 65535) h = 65535;
      if ($urandom_range(9) == 0) begin
        x = $urandom_range(65535);
        y = $urandom_range(65535);
        w = $urandom_range(65535);
        h = $urandom_range(65535);
      end
      if ($urandom_range(29) == 0) w = 0;
      if (r < 60) add_job(OP_MARK, x, y, w, h);
      else if (r < 85) add_job(OP_TAKE, x, y, w, h);
      else if (r < 95) add_job(OP_CLEAR, x, y, w, h);
      else add_job(OpUnused, x, y, w, h);
    end
  endtask

  task automatic drain();
    while (pending_jobs.size() > 0 || in_valid_i || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    frame_w = 0;
    frame_h = 0;
    tile_w = 0;
    tile_h = 0;
    resize_grid();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Grid disabled after reset
    add_job(OP_MARK, 0, 0, 1, 1);
    add_job(OP_TAKE, 0, 0, 0, 0);
    add_job(OP_CLEAR, 0, 0, 0, 0);
    add_job(OpUnused, 65535, 65535, 65535, 65535);
    drain();

    // Small grid: directed marks, rejects, merged and split runs
    set_grid(64, 32, 8, 8);
    add_job(OP_TAKE, 0, 0, 0, 0);
    add_job(OP_MARK, 0, 0, 0, 5);
    add_job(OP_MARK, 0, 0, 5, 0);
    add_job(OP_MARK, 64, 0, 5, 5);
    add_job(OP_MARK, 0, 32, 5, 5);
    add_job(OP_MARK, 0, 0, 16, 16);
    add_job(OP_MARK, 40, 8, 65535, 65535);
    add_job(OP_MARK, 63, 31, 1, 1);
    add_job(OP_TAKE, 0, 0, 0, 0);
    add_job(OP_MARK, 0, 0, 65535, 65535);
    add_job(OP_CLEAR, 0, 0, 0, 0);
    add_job(OP_TAKE, 0, 0, 0, 0);
    add_job(OP_MARK, 8, 0, 8, 32);
    add_job(OP_MARK, 32, 8, 8, 8);
    add_job(OP_TAKE, 0, 0, 0, 0);
    add_random_jobs(75);
    drain();

    // Largest grid, receiver mostly ready, one long hold-off
    send_idle_pct = 77;
    recv_idle_pct = 23;
    set_grid(65535, 65535, 4096, 8192);
    add_job(OP_MARK, 65535, 65535, 65535, 65535);
    add_job(OP_MARK, 0, 0, 65535, 65535);
    add_job(OP_TAKE, 0, 0, 0, 0);
    add_random_jobs(70);
    drain();
    send_idle_pct = 0;
    hold_request = 3000;
    add_random_jobs(10);
    drain();

    // Uneven grid, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(100, 50, 7, 9);
    add_random_jobs(75);
    drain();

    // Too many tiles disables the grid
    set_grid(65535, 65535, 1, 1);
    add_job(OP_MARK, 0, 0, 1, 1);
    add_job(OP_TAKE, 0, 0, 0, 0);
    add_job(OP_CLEAR, 0, 0, 0, 0);
    drain();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
